FILE: rtl/esrm_pkg.sv
// Package for the event sequence rate monitor.
// Holds field widths, operation and register codes, and the history entry type.
// No dependencies.
`default_nettype none
package esrm_pkg;

    localparam int HISTORY_DEPTH_DEF = 64;
    localparam int COMBO_MAX_DEF     = 8;
    localparam int CODE_COUNT_DEF    = 512;

    localparam int OP_W    = 2;
    localparam int CODE_W  = 9;
    localparam int STAMP_W = 17;
    localparam int POS_W   = 3;
    localparam int LIMIT_W = 9;
    localparam int CLEN_W  = 4;
    localparam int CAP_W   = 7;
    localparam int CIDX_W  = 2;

    localparam logic [OP_W-1:0] OP_EVENT = 2'd0;
    localparam logic [OP_W-1:0] OP_COMBO = 2'd1;
    localparam logic [OP_W-1:0] OP_LIMIT = 2'd2;

    localparam logic [CIDX_W-1:0] CFG_COMBO_LEN = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_HIST_CAP  = 2'd1;

    localparam logic signed [LIMIT_W-1:0] UNLIMITED = -9'sd1;

    typedef struct packed {
        logic [CODE_W-1:0]  code;
        logic [STAMP_W-1:0] stamp;
    } hist_entry_t;

endpackage
`default_nettype wire

FILE: rtl/event_sequence_rate_monitor.sv
// Event sequence rate monitor top level: code table, history ring and scan sequencer.
// Depends on esrm_pkg.
//
// After reset the block clears every entry of its code table, with s_tready low.
// It then handles one transaction at a time through a single slot address adder and one
// history read port. A combo or limit write goes straight to the result; an unknown event
// first reads the code table. A known event is pushed into the history; while the trigger
// is not yet armed it is matched against the combo sequence, ending early on a hit; once armed
// it runs a pairwise count over the n stored entries, ending early at the first breach. The
// next transaction is taken once the result is in the output register.
`default_nettype none
module event_sequence_rate_monitor
    import esrm_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
    parameter int COMBO_MAX     = COMBO_MAX_DEF,
    parameter int CODE_COUNT    = CODE_COUNT_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [39:0]       s_tdata,   // event_code, stamp, position, limit, zero pad
    input  wire logic [OP_W-1:0]   s_tuser,   // op
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [7:0]             m_tdata,   // recorded, combo_hit, armed, breach, zero pad
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [CIDX_W-1:0] cfg_index,
    input  wire logic [CAP_W-1:0]  cfg_data
);

    localparam int AW   = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CNTW = $clog2(HISTORY_DEPTH + 1);
    localparam int CI_W = (COMBO_MAX > 1) ? $clog2(COMBO_MAX) : 1;
    localparam int CL_W = $clog2(COMBO_MAX + 1);
    localparam int TW   = (CODE_COUNT > 1) ? $clog2(CODE_COUNT) : 1;
    localparam int TBLW = LIMIT_W + 1;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_LOOKUP, S_PUSH_ADJ, S_PUSH_WR,
        S_C_RD, S_C_CMP, S_B_RDA, S_B_LIM, S_B_LAT, S_B_RD, S_B_CMP, S_FINISH
    } state_t;

    state_t state_reg;

    logic [CODE_W-1:0]  in_code;
    logic [STAMP_W-1:0] in_stamp;
    logic [POS_W-1:0]   in_pos;
    logic [LIMIT_W-1:0] in_limit;
    logic               in_code_ok;
    logic               s_fire;

    assign in_code  = s_tdata[8:0];
    assign in_stamp = s_tdata[25:9];
    assign in_pos   = s_tdata[28:26];
    assign in_limit = s_tdata[37:29];
    assign in_code_ok = (32'(in_code) < CODE_COUNT);
    assign s_fire = s_tvalid && s_tready;

    logic [CLEN_W-1:0] len_reg;
    logic [CAP_W-1:0]  cap_reg;
    logic [CNTW-1:0]   count_reg;
    logic [AW-1:0]     head_reg;
    logic              trig_reg;
    logic [CODE_W-1:0] combo_reg [COMBO_MAX];
    logic [TW-1:0]     clr_reg;
    logic [CNTW-1:0]   kc_reg;
    logic [CNTW-1:0]   mc_reg;
    logic [CNTW-1:0]   cnt_reg;
    logic [CL_W-1:0]   matched_reg;
    logic [CODE_W-1:0] ev_code_reg;
    logic [STAMP_W-1:0] ev_stamp_reg;
    hist_entry_t       a_reg;
    logic signed [LIMIT_W-1:0] lim_reg;
    logic              recorded_reg;
    logic              hit_reg;
    logic              breach_reg;
    logic              m_tvalid_reg;
    logic [7:0]        m_tdata_reg;

    logic [CNTW-1:0] eff_cap;
    logic [CL_W-1:0] eff_len;

    always_comb begin
        if (cap_reg == '0) begin
            eff_cap = CNTW'(1);
        end else if (32'(cap_reg) > HISTORY_DEPTH) begin
            eff_cap = CNTW'(HISTORY_DEPTH);
        end else begin
            eff_cap = CNTW'(cap_reg);
        end
        if (len_reg == '0) begin
            eff_len = CL_W'(1);
        end else if (32'(len_reg) > COMBO_MAX) begin
            eff_len = CL_W'(COMBO_MAX);
        end else begin
            eff_len = CL_W'(len_reg);
        end
    end

    // shared slot unit: (head + k) mod capacity
    logic [CNTW-1:0] k_sel;
    logic [CNTW:0]   slot_sum;
    logic [AW-1:0]   slot;

    always_comb begin
        unique case (state_reg)
            S_PUSH_WR: k_sel = count_reg;
            S_B_RD:    k_sel = mc_reg;
            default:   k_sel = kc_reg;
        endcase
        slot_sum = {1'b0, CNTW'(head_reg)} + {1'b0, k_sel};
        if (slot_sum >= {1'b0, eff_cap}) begin
            slot_sum = slot_sum - {1'b0, eff_cap};
        end
        slot = AW'(slot_sum);
    end

    // history memory
    hist_entry_t hist_mem [HISTORY_DEPTH];
    hist_entry_t hist_rd_reg;
    logic        hist_we;

    assign hist_we = (state_reg == S_PUSH_WR);

    always_ff @(posedge aclk) begin
        if (hist_we) begin
            hist_mem[slot] <= '{code: ev_code_reg, stamp: ev_stamp_reg};
        end
        hist_rd_reg <= hist_mem[slot];
    end

    // code table: known flag and limit
    logic [TBLW-1:0] tbl_mem [CODE_COUNT];
    logic [TBLW-1:0] tbl_rd_reg;
    logic            tbl_we;
    logic [TW-1:0]   tbl_waddr;
    logic [TBLW-1:0] tbl_wdata;
    logic [TW-1:0]   tbl_raddr;

    always_comb begin
        tbl_we    = 1'b0;
        tbl_waddr = TW'(in_code);
        tbl_wdata = {1'b1, in_limit};
        tbl_raddr = TW'(in_code);
        unique case (state_reg)
            S_CLEAR: begin
                tbl_we    = 1'b1;
                tbl_waddr = clr_reg;
                tbl_wdata = '0;
            end
            S_IDLE: begin
                tbl_we = s_fire && (s_tuser == OP_LIMIT) && in_code_ok;
            end
            S_B_LIM: begin
                tbl_raddr = TW'(hist_rd_reg.code);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (tbl_we) begin
            tbl_mem[tbl_waddr] <= tbl_wdata;
        end
        tbl_rd_reg <= tbl_mem[tbl_raddr];
    end

    logic [CNTW-1:0] head_inc;
    logic            pair_eq;
    logic            combo_eq;
    logic            over;

    assign head_inc = CNTW'(head_reg) + CNTW'(1);
    assign pair_eq  = (hist_rd_reg.code == a_reg.code) && (hist_rd_reg.stamp == a_reg.stamp);
    assign combo_eq = (hist_rd_reg.code == combo_reg[CI_W'(matched_reg)]);
    assign over     = (lim_reg != UNLIMITED) &&
                      (int'($signed({1'b0, cnt_reg})) > int'(lim_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            len_reg      <= CLEN_W'(1);
            cap_reg      <= CAP_W'(64);
            count_reg    <= '0;
            head_reg     <= '0;
            trig_reg     <= 1'b0;
            clr_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready && state_reg != S_FINISH) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_valid) begin
                if (cfg_index == CFG_COMBO_LEN) begin
                    len_reg <= CLEN_W'(cfg_data);
                end else if (cfg_index == CFG_HIST_CAP) begin
                    cap_reg   <= cfg_data;
                    count_reg <= '0;
                    head_reg  <= '0;
                end
            end
            unique case (state_reg)
                S_CLEAR: begin
                    clr_reg <= clr_reg + TW'(1);
                    if (32'(clr_reg) == CODE_COUNT - 1) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_fire) begin
                        recorded_reg <= 1'b0;
                        hit_reg      <= 1'b0;
                        breach_reg   <= 1'b0;
                        ev_code_reg  <= in_code;
                        ev_stamp_reg <= in_stamp;
                        state_reg    <= S_FINISH;
                        if (s_tuser == OP_COMBO && 32'(in_pos) < COMBO_MAX) begin
                            combo_reg[CI_W'(in_pos)] <= in_code;
                        end
                        if (s_tuser == OP_EVENT && in_code_ok) begin
                            state_reg <= S_LOOKUP;
                        end
                    end
                end
                S_LOOKUP: begin
                    state_reg <= tbl_rd_reg[TBLW-1] ? S_PUSH_ADJ : S_FINISH;
                end
                S_PUSH_ADJ: begin
                    if (count_reg >= eff_cap) begin
                        head_reg  <= (head_inc == eff_cap) ? '0 : AW'(head_inc);
                        count_reg <= eff_cap - CNTW'(1);
                    end
                    state_reg <= S_PUSH_WR;
                end
                S_PUSH_WR: begin
                    count_reg    <= count_reg + CNTW'(1);
                    recorded_reg <= 1'b1;
                    kc_reg       <= '0;
                    matched_reg  <= '0;
                    state_reg    <= trig_reg ? S_B_RDA : S_C_RD;
                end
                S_C_RD: begin
                    state_reg <= (kc_reg >= count_reg) ? S_FINISH : S_C_CMP;
                end
                S_C_CMP: begin
                    kc_reg    <= kc_reg + CNTW'(1);
                    state_reg <= S_C_RD;
                    if (combo_eq) begin
                        matched_reg <= matched_reg + CL_W'(1);
                        if (matched_reg + CL_W'(1) >= eff_len) begin
                            hit_reg   <= 1'b1;
                            trig_reg  <= 1'b1;
                            state_reg <= S_FINISH;
                        end
                    end
                end
                S_B_RDA: begin
                    state_reg <= (kc_reg >= count_reg) ? S_FINISH : S_B_LIM;
                end
                S_B_LIM: begin
                    a_reg     <= hist_rd_reg;
                    mc_reg    <= kc_reg + CNTW'(1);
                    cnt_reg   <= CNTW'(1);
                    state_reg <= S_B_LAT;
                end
                S_B_LAT: begin
                    lim_reg   <= $signed(tbl_rd_reg[LIMIT_W-1:0]);
                    state_reg <= S_B_RD;
                end
                S_B_RD: begin
                    if (mc_reg >= count_reg) begin
                        if (over) begin
                            breach_reg <= 1'b1;
                            state_reg  <= S_FINISH;
                        end else begin
                            kc_reg    <= kc_reg + CNTW'(1);
                            state_reg <= S_B_RDA;
                        end
                    end else begin
                        state_reg <= S_B_CMP;
                    end
                end
                S_B_CMP: begin
                    if (pair_eq) begin
                        cnt_reg <= cnt_reg + CNTW'(1);
                    end
                    mc_reg    <= mc_reg + CNTW'(1);
                    state_reg <= S_B_RD;
                end
                S_FINISH: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {4'b0, breach_reg, trig_reg, hit_reg, recorded_reg};
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

endmodule
`default_nettype wire

FILE: rtl/esrm_checker.sv
// Port-level checker for the event sequence rate monitor, bound to the top level.
// Depends on esrm_pkg.
`default_nettype none
module esrm_checker
    import esrm_pkg::*;
(
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              s_tvalid,
    input wire logic              s_tready,
    input wire logic              m_tvalid,
    input wire logic              m_tready,
    input wire logic [7:0]        m_tdata
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_hit_arms: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1] |-> m_tdata[2] && m_tdata[0])
        else $error("combo hit without armed or recorded");

    a_breach_ctx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[3] |-> m_tdata[0] && m_tdata[2] && !m_tdata[1])
        else $error("breach outside armed recorded event");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("transaction taken while busy");

endmodule

bind event_sequence_rate_monitor esrm_checker u_esrm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire

FILE: tb/esrm_checker.sv
// Checker for the event sequence rate monitor: watches the input, result and register
// channels, predicts each result and compares it with the block's output.
// Depends on esrm_pkg.
`timescale 1ns / 100ps
module esrm_scoreboard
    import esrm_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    input  wire logic              s_tready,
    input  wire logic [39:0]       s_tdata,
    input  wire logic [OP_W-1:0]   s_tuser,
    input  wire logic              m_tvalid,
    input  wire logic              m_tready,
    input  wire logic [7:0]        m_tdata,
    input  wire logic              cfg_valid,
    input  wire logic              cfg_ready,
    input  wire logic [CIDX_W-1:0] cfg_index,
    input  wire logic [CAP_W-1:0]  cfg_data,
    output int                     errors,
    output int                     pending
);

    localparam int HDEPTH = HISTORY_DEPTH_DEF;
    localparam int CMAX   = COMBO_MAX_DEF;
    localparam int NCODES = CODE_COUNT_DEF;

    logic [CODE_W-1:0]         ring_code [HDEPTH];
    logic [STAMP_W-1:0]        ring_stamp[HDEPTH];
    int                        ring_fill;
    int                        ring_head;
    logic [CODE_W-1:0]         combo_seq[CMAX];
    logic                      known[NCODES];
    logic signed [LIMIT_W-1:0] repeat_cap[NCODES];
    logic                      armed_q;
    logic [CLEN_W-1:0]         combo_len_reg;
    logic [CAP_W-1:0]          capacity_reg;
    logic [3:0]                expected_flags[$];

    function automatic int ring_size();
        if (capacity_reg == 0) return 1;
        if (capacity_reg > HDEPTH) return HDEPTH;
        return int'(capacity_reg);
    endfunction

    function automatic int combo_size();
        if (combo_len_reg == 0) return 1;
        if (combo_len_reg > CMAX) return CMAX;
        return int'(combo_len_reg);
    endfunction

    function automatic bit sequence_seen();
        int matched;
        matched = 0;
        for (int k = 0; k < ring_fill; k++) begin
            if (ring_code[(ring_head + k) % ring_size()] == combo_seq[matched]) begin
                matched++;
                if (matched >= combo_size()) return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic bit over_limit();
        int a;
        int b;
        int hits;
        for (int k = 0; k < ring_fill; k++) begin
            a = (ring_head + k) % ring_size();
            hits = 1;
            for (int m = k + 1; m < ring_fill; m++) begin
                b = (ring_head + m) % ring_size();
                if (ring_code[b] == ring_code[a] && ring_stamp[b] == ring_stamp[a]) hits++;
            end
            if (repeat_cap[ring_code[a]] != UNLIMITED && hits > int'(repeat_cap[ring_code[a]]))
                return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic predict_flags(input logic [OP_W-1:0] op, input logic [39:0] data);
        logic [CODE_W-1:0]         code;
        logic [STAMP_W-1:0]        stamp;
        logic [POS_W-1:0]          pos;
        logic signed [LIMIT_W-1:0] lim;
        logic                      rec;
        logic                      hit;
        logic                      brk;
        code  = data[8:0];
        stamp = data[25:9];
        pos   = data[28:26];
        lim   = data[37:29];
        rec   = 1'b0;
        hit   = 1'b0;
        brk   = 1'b0;
        if (op == OP_COMBO) begin
            combo_seq[pos] = code;
        end else if (op == OP_LIMIT) begin
            known[code]      = 1'b1;
            repeat_cap[code] = lim;
        end else if (op == OP_EVENT && known[code]) begin
            if (ring_fill >= ring_size()) begin
                ring_head = (ring_head + 1) % ring_size();
                ring_fill = ring_size() - 1;
            end
            ring_code[(ring_head + ring_fill) % ring_size()]  = code;
            ring_stamp[(ring_head + ring_fill) % ring_size()] = stamp;
            ring_fill++;
            rec = 1'b1;
            if (!armed_q) begin
                if (sequence_seen()) begin
                    armed_q = 1'b1;
                    hit     = 1'b1;
                end
            end else begin
                brk = over_limit();
            end
        end
        expected_flags.push_back({brk, armed_q, hit, rec});
    endtask

    always @(posedge aclk) begin
        logic [3:0] want;
        if (!aresetn) begin
            errors        = 0;
            ring_fill     = 0;
            ring_head     = 0;
            armed_q       = 1'b0;
            combo_len_reg = 4'd1;
            capacity_reg  = 7'd64;
            for (int i = 0; i < NCODES; i++) known[i] = 1'b0;
            expected_flags.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_COMBO_LEN) begin
                    combo_len_reg = cfg_data[CLEN_W-1:0];
                end else if (cfg_index == CFG_HIST_CAP) begin
                    capacity_reg = cfg_data;
                    ring_fill    = 0;
                    ring_head    = 0;
                end
            end
            if (m_tvalid && m_tready) begin
                if (expected_flags.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %b",
                             $time, m_tdata[3:0]);
                    errors++;
                end else begin
                    want = expected_flags.pop_front();
                    if (m_tdata[0] !== want[0])
                        $display("%0t: recorded mismatch, expected %b, actual %b",
                                 $time, want[0], m_tdata[0]);
                    if (m_tdata[1] !== want[1])
                        $display("%0t: combo_hit mismatch, expected %b, actual %b",
                                 $time, want[1], m_tdata[1]);
                    if (m_tdata[2] !== want[2])
                        $display("%0t: armed mismatch, expected %b, actual %b",
                                 $time, want[2], m_tdata[2]);
                    if (m_tdata[3] !== want[3])
                        $display("%0t: breach mismatch, expected %b, actual %b",
                                 $time, want[3], m_tdata[3]);
                    if (m_tdata[3:0] !== want) errors++;
                end
            end
            if (s_tvalid && s_tready) predict_flags(s_tuser, s_tdata);
        end
        pending = expected_flags.size();
    end

endmodule

FILE: tb/tb_event_sequence_rate_monitor.sv
// Testbench top for the event sequence rate monitor: clock, reset, stimulus and verdict.
// Depends on esrm_pkg, event_sequence_rate_monitor and esrm_scoreboard.
`timescale 1ns / 100ps
module tb_event_sequence_rate_monitor;
    import esrm_pkg::*;

    localparam int IDLE_LIMIT = 20000;
    localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;

    logic              aclk;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    logic [39:0]       s_tdata;
    logic [OP_W-1:0]   s_tuser;
    logic              m_tvalid;
    logic              m_tready;
    logic [7:0]        m_tdata;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [CIDX_W-1:0] cfg_index;
    logic [CAP_W-1:0]  cfg_data;
    int                errors;
    int                pending;
    int                burst_left;
    int                quiet_cycles;
    bit                long_hold_req;

    event_sequence_rate_monitor DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    esrm_scoreboard u_scoreboard (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .errors(errors), .pending(pending)
    );

    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("** event_sequence_rate_monitor: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int mode;
        m_tready = 1'b0;
        forever begin
            mode = $urandom_range(0, 2);
            repeat ($urandom_range(16, 96)) begin
                @(negedge aclk);
                if (long_hold_req) begin
                    m_tready <= 1'b0;
                    repeat (400) @(negedge aclk);
                    long_hold_req = 1'b0;
                end else if (mode == 0) begin
                    m_tready <= 1'b1;
                end else if (mode == 1) begin
                    m_tready <= 1'($urandom_range(0, 1));
                end else begin
                    m_tready <= ($urandom_range(0, 3) == 0);
                end
            end
        end
    end

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CAP_W-1:0] value);
        while (pending != 0) @(negedge aclk);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_item(input logic [OP_W-1:0] op, input logic [CODE_W-1:0] code,
                             input logic [STAMP_W-1:0] stamp, input logic [POS_W-1:0] pos,
                             input logic [LIMIT_W-1:0] lim);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(0, 20)) @(negedge aclk);
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        s_tdata  <= {2'b00, lim, pos, stamp, code};
        s_tuser  <= op;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic send_random();
        int pick;
        logic [CODE_W-1:0]  code;
        logic [STAMP_W-1:0] stamp;
        logic [LIMIT_W-1:0] lim;
        pick  = $urandom_range(0, 99);
        code  = ($urandom_range(0, 9) == 0) ? CODE_W'($urandom_range(0, 511))
                                             : CODE_W'($urandom_range(0, 11));
        stamp = ($urandom_range(0, 9) < 7) ? STAMP_W'($urandom_range(0, 3))
                                            : STAMP_W'($urandom_range(0, 86399));
        case ($urandom_range(0, 3))
            0:       lim = UNLIMITED;
            1:       lim = LIMIT_W'($urandom_range(0, 511));
            default: lim = LIMIT_W'($urandom_range(0, 3));
        endcase
        if (pick < 75)
            send_item(OP_EVENT, code, stamp, POS_W'($urandom_range(0, 7)), lim);
        else if (pick < 88)
            send_item(OP_LIMIT, code, stamp, POS_W'($urandom_range(0, 7)), lim);
        else if (pick < 95)
            send_item(OP_COMBO, code, stamp, POS_W'($urandom_range(0, 7)), lim);
        else
            send_item(OP_RESERVED, CODE_W'($urandom_range(0, 511)), stamp,
                      POS_W'($urandom_range(0, 7)), LIMIT_W'($urandom_range(0, 511)));
    endtask

    initial begin
        logic [CLEN_W-1:0] lens[9];
        logic [CAP_W-1:0]  caps[9];
        int                count;
        lens = '{4'd1, 4'd8, 4'd4, 4'd2, 4'd0, 4'd7, 4'd8, 4'd15, 4'd3};
        caps = '{7'd1, 7'd64, 7'd12, 7'd5, 7'd0, 7'd16, 7'd3, 7'd100, 7'd9};
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = OP_EVENT;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_COMBO_LEN;
        cfg_data      = '0;
        burst_left    = 0;
        long_hold_req = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        write_reg(CFG_COMBO_LEN, 7'd3);
        write_reg(CFG_HIST_CAP, 7'd8);
        send_item(OP_COMBO, 9'd7,   '0, 3'd0, '0);
        send_item(OP_COMBO, 9'd3,   '0, 3'd1, '0);
        send_item(OP_COMBO, 9'd7,   '0, 3'd2, '0);
        send_item(OP_COMBO, 9'd511, '0, 3'd3, '0);
        send_item(OP_COMBO, 9'd0,   '0, 3'd4, '0);
        send_item(OP_COMBO, 9'd1,   '0, 3'd5, '0);
        send_item(OP_COMBO, 9'd2,   '0, 3'd6, '0);
        send_item(OP_COMBO, 9'd4,   '0, 3'd7, '0);
        send_item(OP_LIMIT, 9'd7,   '0, 3'd0, 9'd1);
        send_item(OP_LIMIT, 9'd3,   '0, 3'd0, UNLIMITED);
        send_item(OP_LIMIT, 9'd511, '0, 3'd0, 9'd255);
        send_item(OP_LIMIT, 9'd0,   '0, 3'd0, -9'sd2);
        send_item(OP_LIMIT, 9'd1,   '0, 3'd0, 9'h100);
        send_item(OP_EVENT, 9'd100, 17'd5, 3'd7, 9'h1FF);
        send_item(OP_RESERVED, 9'd7, '0, 3'd7, 9'd0);
        send_item(OP_EVENT, 9'd7,   '0, 3'd0, '0);
        send_item(OP_EVENT, 9'd511, 17'd86399, 3'd0, '0);
        send_item(OP_EVENT, 9'd3,   17'd5, 3'd0, '0);
        send_item(OP_EVENT, 9'd7,   '0, 3'd0, '0);
        send_item(OP_EVENT, 9'd7,   '0, 3'd0, '0);
        send_item(OP_EVENT, 9'd511, 17'd86399, 3'd0, '0);
        send_item(OP_LIMIT, 9'd7,   '0, 3'd0, UNLIMITED);
        send_item(OP_EVENT, 9'd0,   17'd86399, 3'd0, '0);
        send_item(OP_EVENT, 9'd1,   17'd1, 3'd0, '0);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);

        for (int ph = 0; ph < 9; ph++) begin
            write_reg(CFG_COMBO_LEN, {3'b000, lens[ph]});
            write_reg(CFG_HIST_CAP, caps[ph]);
            count = (caps[ph] > 16) ? 40 : 120;
            for (int n = 0; n < count; n++) begin
                if (ph == 2 && n == 30) long_hold_req = 1'b1;
                send_random();
            end
            s_tvalid <= 1'b0;
        end

        while (pending != 0) @(negedge aclk);
        repeat (50) @(negedge aclk);
        if (errors == 0) begin
            $display("** event_sequence_rate_monitor: PASSED **");
        end else begin
            $display("** event_sequence_rate_monitor: FAILED **");
        end
        $finish;
    end

endmodule
